>>> design/ac_rle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ac_rle_pkg;

    // Fixed field widths of a result beat
    localparam int RUN_W   = 4;
    localparam int LEVEL_W = 16;

    // Default block geometry
    localparam int BLOCK_AC_COEFS_DEF = 63;
    localparam int ZERO_RUN_LIMIT_DEF = 16;

    // One (run, level) pair as it leaves the block
    typedef struct packed {
        logic [RUN_W-1:0]          run_length;
        logic signed [LEVEL_W-1:0] level;
        logic                      block_end;
        logic                      last;
    } t_pair;

    // Up to two pairs caused by one coefficient, in order
    typedef struct packed {
        t_pair      pair0;
        t_pair      pair1;
        logic [1:0] count;
    } t_enc;

endpackage

`default_nettype wire

>>> design/ac_rle_encode.sv
`timescale 1ns / 1ps
`default_nettype none

module ac_rle_encode
    import ac_rle_pkg::*;
#(
    parameter int BLOCK_AC_COEFS = BLOCK_AC_COEFS_DEF,
    parameter int ZERO_RUN_LIMIT = ZERO_RUN_LIMIT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic signed [LEVEL_W-1:0] i_coefficient,
    input  wire logic                      i_advance,
    output t_enc                           o_enc
);

    localparam int ZRW = $clog2(ZERO_RUN_LIMIT);
    localparam int PW  = $clog2(BLOCK_AC_COEFS + 1);

    localparam logic [ZRW-1:0] RUN_MAX   = ZRW'(ZERO_RUN_LIMIT - 1);
    localparam logic [PW-1:0]  LAST_POS  = PW'(BLOCK_AC_COEFS - 1);
    localparam logic [PW-1:0]  BLOCK_CNT = PW'(BLOCK_AC_COEFS);

    logic [ZRW-1:0] r_zero_run, n_zero_run;
    logic [PW-1:0]  r_position, n_position;
    logic [PW-1:0]  r_pair_count, n_pair_count;

    logic             nonzero;
    logic             marker;
    logic             first_valid;
    logic             final_coef;
    logic             eob;
    logic [PW-1:0]    pair_cnt_next;
    logic [ZRW+RUN_W-1:0] run_ext;
    logic [ZRW+RUN_W-1:0] max_ext;
    t_pair            first_pair;
    t_pair            eob_pair;

    // Classify the coefficient against the current run
    always_comb begin
        nonzero       = (i_coefficient != '0);
        marker        = !nonzero && (r_zero_run == RUN_MAX);
        first_valid   = nonzero || marker;
        pair_cnt_next = r_pair_count + PW'(first_valid);
        final_coef    = (r_position == LAST_POS);
        eob           = final_coef && (pair_cnt_next < BLOCK_CNT);
        run_ext       = {{RUN_W{1'b0}}, r_zero_run};
        max_ext       = {{RUN_W{1'b0}}, RUN_MAX};
    end

    // Build the level or marker pair and the end-of-block pair
    always_comb begin
        first_pair.run_length = nonzero ? run_ext[RUN_W-1:0] : max_ext[RUN_W-1:0];
        first_pair.level      = nonzero ? i_coefficient : '0;
        first_pair.block_end  = final_coef && !eob;
        first_pair.last       = !eob;

        eob_pair.run_length = '0;
        eob_pair.level      = '0;
        eob_pair.block_end  = 1'b1;
        eob_pair.last       = 1'b1;

        o_enc.pair0 = first_valid ? first_pair : eob_pair;
        o_enc.pair1 = eob_pair;
        o_enc.count = 2'(first_valid) + 2'(eob);
    end

    // Advance run, position and pair count; clear at block end
    always_comb begin
        n_zero_run   = r_zero_run;
        n_position   = r_position;
        n_pair_count = r_pair_count;
        if (i_advance) begin
            if (final_coef) begin
                n_zero_run   = '0;
                n_position   = '0;
                n_pair_count = '0;
            end else begin
                n_zero_run   = first_valid ? '0 : r_zero_run + ZRW'(1);
                n_position   = r_position + PW'(1);
                n_pair_count = pair_cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run   <= '0;
            r_position   <= '0;
            r_pair_count <= '0;
        end else begin
            r_zero_run   <= n_zero_run;
            r_position   <= n_position;
            r_pair_count <= n_pair_count;
        end
    end

    a_run_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_run <= RUN_MAX)
        else $error("zero run reached the limit without a marker");

    a_position_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= LAST_POS)
        else $error("coefficient position ran past the block");

    a_pairs_follow_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_count <= r_position)
        else $error("more pairs than coefficients in the block");

endmodule

`default_nettype wire

>>> design/ac_rle_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ac_rle_out_queue
    import ac_rle_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_enc      i_enc,
    input  wire logic i_stall,
    output logic      o_valid,
    output t_pair     o_pair,
    output logic [1:0] o_free
);

    t_pair      r_slot [0:1];
    t_pair      n_slot [0:1];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_pair  = r_slot[0];
    assign pop     = o_valid && !i_stall;
    assign base    = r_count - 2'(pop);
    assign o_free  = 2'd2 - base;

    // Drop the head on a taken beat, then append new pairs behind what is kept
    always_comb begin
        n_slot[0] = r_slot[0];
        n_slot[1] = r_slot[1];
        n_count   = base;
        if (pop) begin
            n_slot[0] = r_slot[1];
        end
        if (i_push) begin
            case (base)
                2'd0: begin
                    n_slot[0] = i_enc.pair0;
                    n_slot[1] = i_enc.pair1;
                end
                2'd1: begin
                    n_slot[1] = i_enc.pair0;
                end
                default: begin
                end
            endcase
            n_count = base + i_enc.count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output queue over capacity");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_enc.count <= o_free))
        else $error("pairs pushed without room");

endmodule

`default_nettype wire

>>> design/ac_run_length_encoder_core.sv
// Path: a coefficient accepted into the input register is encoded combinationally, and its
// pairs enter the output queue once they fit; the queue head drives the outputs.
// Throughput: one coefficient per cycle while the sink takes a beat each cycle; an item
// with two pairs needs both queue slots and stalls the input while a pair stays.
// Reset: synchronous, active low; clears input valid, run, position, pair count, queue fill.
`timescale 1ns / 1ps
`default_nettype none

module ac_run_length_encoder_core
    import ac_rle_pkg::*;
#(
    parameter int BLOCK_AC_COEFS = BLOCK_AC_COEFS_DEF,
    parameter int ZERO_RUN_LIMIT = ZERO_RUN_LIMIT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [LEVEL_W-1:0] i_coefficient,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [RUN_W-1:0]               o_run_length,
    output logic signed [LEVEL_W-1:0]      o_level,
    output logic                           o_block_end,
    output logic                           o_last
);

    logic                      r_in_valid;
    logic signed [LEVEL_W-1:0] r_in_coef;
    logic                      fire;
    logic [1:0]                free;
    t_enc                      enc;
    t_pair                     out_pair;

    // Move the held coefficient into the queue once its pairs fit
    assign fire    = r_in_valid && (enc.count <= free);
    assign o_stall = r_in_valid && !fire;

    // Input register: load on every accepted beat
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_coef <= i_coefficient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    ac_rle_encode #(
        .BLOCK_AC_COEFS (BLOCK_AC_COEFS),
        .ZERO_RUN_LIMIT (ZERO_RUN_LIMIT)
    ) u_encode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coefficient (r_in_coef),
        .i_advance     (fire),
        .o_enc         (enc)
    );

    ac_rle_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_enc   (enc),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_pair  (out_pair),
        .o_free  (free)
    );

    assign o_run_length = out_pair.run_length;
    assign o_level      = out_pair.level;
    assign o_block_end  = out_pair.block_end;
    assign o_last       = out_pair.last;

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with an empty input register");

    a_held_coef_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_coef)))
        else $error("held coefficient changed before it was encoded");

    a_block_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_block_end) |-> o_last)
        else $error("block end beat not marked last");

endmodule

`default_nettype wire

>>> tb/ac_run_length_encoder_core_tb.sv
`timescale 1ns / 1ps

module ac_run_length_encoder_core_tb;
    import ac_rle_pkg::*;

    localparam int BLOCK_COEFS   = BLOCK_AC_COEFS_DEF;
    localparam int RUN_LIMIT     = ZERO_RUN_LIMIT_DEF;
    localparam int RANDOM_ITEMS  = 250;   // per idling phase
    localparam int QUIET_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // Shapes of a whole block of coefficients
    typedef enum int {
        MODE_NOISE,
        MODE_FULL,
        MODE_EMPTY,
        MODE_SPARSE,
        MODE_TAIL_MARKER,
        MODE_LAST_ONLY,
        MODE_RUN15
    } block_mode_e;

    // Predicts the pairs of each coefficient and checks the block's output against them
    class rle_scoreboard;
        int unsigned zero_run;
        int unsigned coef_pos;
        int unsigned pair_cnt;
        t_pair       expected_pairs[$];
        int          errors;

        function t_pair make_pair(input int unsigned run, input logic signed [LEVEL_W-1:0] lvl);
            t_pair p;
            p.run_length = RUN_W'(run);
            p.level      = lvl;
            p.block_end  = 1'b0;
            p.last       = 1'b0;
            return p;
        endfunction

        function void encode_coef(input logic signed [LEVEL_W-1:0] coef);
            t_pair step_pairs[$];
            bit    final_coef;
            final_coef = (coef_pos + 1 >= BLOCK_COEFS);
            // level pair, or extend the run and emit a marker when it fills
            if (coef != '0) begin
                step_pairs.push_back(make_pair(zero_run, coef));
                pair_cnt++;
                zero_run = 0;
            end else begin
                zero_run++;
                if (zero_run >= RUN_LIMIT) begin
                    step_pairs.push_back(make_pair(RUN_LIMIT - 1, '0));
                    pair_cnt++;
                    zero_run = 0;
                end
            end
            // close the block with end-of-block unless it is already full
            if (final_coef) begin
                if (pair_cnt < BLOCK_COEFS)
                    step_pairs.push_back(make_pair(0, '0));
                if (step_pairs.size() > 0)
                    step_pairs[step_pairs.size()-1].block_end = 1'b1;
                zero_run = 0;
                coef_pos = 0;
                pair_cnt = 0;
            end else begin
                coef_pos++;
            end
            if (step_pairs.size() > 0)
                step_pairs[step_pairs.size()-1].last = 1'b1;
            foreach (step_pairs[i])
                expected_pairs.push_back(step_pairs[i]);
        endfunction

        function void check_pair(input t_pair got);
            t_pair want;
            if (expected_pairs.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected pair run %0d level %0d end %0b last %0b",
                             $time, got.run_length, got.level, got.block_end, got.last);
                return;
            end
            want = expected_pairs.pop_front();
            if (got.run_length !== want.run_length || got.level !== want.level ||
                got.block_end !== want.block_end || got.last !== want.last) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: pair mismatch: expected run %0d level %0d end %0b last %0b, got run %0d level %0d end %0b last %0b",
                             $time, want.run_length, want.level, want.block_end, want.last,
                             got.run_length, got.level, got.block_end, got.last);
            end
        endfunction

        function int pending_count();
            return expected_pairs.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_stall;
    logic signed [LEVEL_W-1:0] i_coefficient = '0;
    logic                      o_valid;
    logic                      i_stall       = 1'b0;
    logic [RUN_W-1:0]          o_run_length;
    logic signed [LEVEL_W-1:0] o_level;
    logic                      o_block_end;
    logic                      o_last;

    rle_scoreboard sb = new();
    int            src_idle_pct = 37;
    int            snk_stall_pct = 87;
    int            quiet_cycles = 0;
    int unsigned   stim_pos = 0;
    block_mode_e   block_mode = MODE_NOISE;

    ac_run_length_encoder_core #(
        .BLOCK_AC_COEFS(BLOCK_COEFS),
        .ZERO_RUN_LIMIT(RUN_LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_coefficient(i_coefficient),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_run_length (o_run_length),
        .o_level      (o_level),
        .o_block_end  (o_block_end),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the output side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    // Track input beats, check output beats, count quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.encode_coef(i_coefficient);
            if (o_valid && !i_stall)
                sb.check_pair('{run_length: o_run_length, level: o_level,
                                block_end: o_block_end, last: o_last});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Abort a hung run
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [LEVEL_W-1:0] rand_level();
        logic [LEVEL_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'h0001;
            3:       v = 16'hFFFF;
            default: begin
                v = LEVEL_W'($urandom);
                if (v == '0)
                    v = 16'h0001;
            end
        endcase
        return v;
    endfunction

    // Next coefficient of the current block shape; pick a new shape at each block start
    function automatic logic signed [LEVEL_W-1:0] next_coef();
        logic signed [LEVEL_W-1:0] c;
        if (stim_pos == 0)
            block_mode = block_mode_e'($urandom_range(int'(MODE_RUN15)));
        case (block_mode)
            MODE_NOISE:       c = $urandom_range(1) ? rand_level() : '0;
            MODE_FULL:        c = rand_level();
            MODE_EMPTY:       c = '0;
            MODE_SPARSE:      c = ($urandom_range(9) == 0) ? rand_level() : '0;
            MODE_TAIL_MARKER: begin
                if (stim_pos == BLOCK_COEFS - RUN_LIMIT - 1)
                    c = rand_level();
                else if (stim_pos < BLOCK_COEFS - RUN_LIMIT - 1 && $urandom_range(1))
                    c = rand_level();
                else
                    c = '0;
            end
            MODE_LAST_ONLY:   c = (stim_pos == BLOCK_COEFS - 1) ? rand_level() : '0;
            default:          c = (stim_pos % RUN_LIMIT == RUN_LIMIT - 1) ? rand_level() : '0;
        endcase
        stim_pos = (stim_pos + 1) % BLOCK_COEFS;
        return c;
    endfunction

    // Drive one coefficient beat after a random gap; return at its accepting edge
    task automatic send_coef(input logic signed [LEVEL_W-1:0] coef);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid       <= 1'b0;
            i_coefficient <= LEVEL_W'($urandom);
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_coefficient <= coef;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold off input until every predicted pair has come out
    task automatic drain_pairs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    initial begin
        logic signed [LEVEL_W-1:0] directed[$];
        directed = '{16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0005,
                     16'sh5555, 16'shAAAA};
        repeat (RUN_LIMIT) directed.push_back('0);
        directed.push_back(-16'sd7);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, run of one, full zero run with marker
        foreach (directed[i]) begin
            send_coef(directed[i]);
            stim_pos = (stim_pos + 1) % BLOCK_COEFS;
        end
        drain_pairs();

        // Random blocks under three idling profiles
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 37; snk_stall_pct = 87; end
                1:       begin src_idle_pct = 87; snk_stall_pct = 37; end
                default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            endcase
            repeat (RANDOM_ITEMS) send_coef(next_coef());
            drain_pairs();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #1;
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
